@@ rtl/imufd_pkg.sv @@
// Package for the inertial sensor frame decoder: frame constants, type codes,
// scaling tables and the lane records carried through the scaling pipeline.
// No dependencies.
`timescale 1ns / 1ps

package imufd_pkg;

	// Frame layout: header, type byte, eight data bytes, checksum byte
	localparam int FRAME_LENGTH = 11;
	localparam int CSUM_POS     = FRAME_LENGTH - 1;
	localparam int BODY_BYTES   = FRAME_LENGTH - 2;
	localparam int POS_W        = 4;
	localparam int IDX_W        = 4;
	localparam int LANES        = 4;

	localparam logic [7:0] HDR_BYTE    = 8'h55;
	localparam logic [7:0] TYPE_TIME   = 8'h50;
	localparam logic [7:0] TYPE_ACCEL  = 8'h51;
	localparam logic [7:0] TYPE_GYRO   = 8'h52;
	localparam logic [7:0] TYPE_ANGLE  = 8'h53;
	localparam logic [7:0] TYPE_MAG    = 8'h54;
	localparam logic [7:0] TYPE_PRESS  = 8'h56;
	localparam logic [7:0] TYPE_QUAT   = 8'h59;

	typedef enum logic [2:0] {
		KIND_TIME  = 3'd0,
		KIND_ACCEL = 3'd1,
		KIND_GYRO  = 3'd2,
		KIND_ANGLE = 3'd3,
		KIND_MAG   = 3'd4,
		KIND_PRESS = 3'd5,
		KIND_QUAT  = 3'd6
	} kind_t;

	// How a lane is turned into its result value
	typedef enum logic [2:0] {
		SC_PASS,
		SC_ACCEL,
		SC_GYRO,
		SC_MAG,
		SC_TEMP
	} scale_t;

	// Rounded scaling: q = floor((mag * MUL + ADD) / DIV), done as a reciprocal
	// multiply on a 30-bit dividend. Gyro rate is 69 * mag plus the rounded
	// fraction 182963 / 225000 of mag, with the divide split into >> 3 and / 28125.
	localparam int DIVIDEND_W = 30;
	localparam int POST_DIV5  = DIVIDEND_W + 3;
	localparam int POST_DIV25 = DIVIDEND_W + 5;
	localparam int POST_GYRO  = DIVIDEND_W + 15;
	localparam int GYRO_PRE   = 3;

	localparam logic [30:0] RCP_DIV5  = 31'((64'd1 << POST_DIV5) / 64'd5 + 64'd1);
	localparam logic [30:0] RCP_DIV25 = 31'((64'd1 << POST_DIV25) / 64'd25 + 64'd1);
	localparam logic [30:0] RCP_GYRO  = 31'((64'd1 << POST_GYRO) / 64'd28125 + 64'd1);
	localparam logic [6:0]  GYRO_WHOLE = 7'd69;

	typedef struct packed {
		scale_t      scale;
		logic        neg;
		logic [15:0] mag;
		logic [31:0] pass;
	} lane_s1_t;

	typedef struct packed {
		scale_t                  scale;
		logic                    neg;
		logic [DIVIDEND_W-1:0]   dvd;
		logic [22:0]             base;
		logic [31:0]             pass;
	} lane_s2_t;

	typedef struct packed {
		scale_t      scale;
		logic        neg;
		logic [24:0] quo;
		logic [22:0] base;
		logic [31:0] pass;
	} lane_s3_t;

	function automatic logic [17:0] scale_mul(scale_t sc);
		logic [17:0] m;
		unique case (sc)
			SC_ACCEL: m = 18'd1568;
			SC_GYRO:  m = 18'd182963;
			SC_MAG:   m = 18'd24576;
			SC_TEMP:  m = 18'd16384;
			default:  m = 18'd0;
		endcase
		return m;
	endfunction

	function automatic logic [16:0] scale_add(scale_t sc);
		logic [16:0] a;
		unique case (sc)
			SC_ACCEL: a = 17'd2;
			SC_GYRO:  a = 17'd112500;
			SC_MAG:   a = 17'd12;
			SC_TEMP:  a = 17'd12;
			default:  a = 17'd0;
		endcase
		return a;
	endfunction

	function automatic logic [30:0] scale_rcp(scale_t sc);
		logic [30:0] r;
		unique case (sc)
			SC_ACCEL: r = RCP_DIV5;
			SC_GYRO:  r = RCP_GYRO;
			SC_MAG:   r = RCP_DIV25;
			SC_TEMP:  r = RCP_DIV25;
			default:  r = 31'd0;
		endcase
		return r;
	endfunction

	// Split a signed 16-bit word into sign and magnitude for scaling
	function automatic lane_s1_t lane_from_word(scale_t sc, logic [15:0] w);
		lane_s1_t l;
		l.scale = sc;
		l.neg   = w[15];
		l.mag   = w[15] ? 16'(16'd0 - w) : w;
		l.pass  = 32'd0;
		return l;
	endfunction

	// Lane whose result is taken as is
	function automatic lane_s1_t lane_from_value(logic [31:0] v);
		lane_s1_t l;
		l.scale = SC_PASS;
		l.neg   = 1'b0;
		l.mag   = 16'd0;
		l.pass  = v;
		return l;
	endfunction

endpackage

@@ rtl/imu_serial_frame_decoder_unit.sv @@
// Inertial sensor serial frame decoder: byte collector, frame decode and
// four-lane scaling pipeline with output register. Depends on imufd_pkg.
`timescale 1ns / 1ps

// Takes one received byte per cycle, hunts for the 0x55 header and collects
// the type byte and nine more bytes (the checksum is not checked). On the
// checksum byte a known frame type launches into a four-lane pipeline
// (multiply, reciprocal divide, round and sign) and its result passes through
// stages s1, s2 and s3 into the output register. Bytes are taken back to back;
// the input stalls only on a checksum byte while the first pipeline stage is
// blocked by a stalled output, and one result can wait at the output while the
// next frame streams in. Scaled values are Q16.16, rounded half away from zero.
module imu_serial_frame_decoder_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         rx_byte,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [2:0]         record_kind,
	output logic signed [31:0] value_a,
	output logic signed [31:0] value_b,
	output logic signed [31:0] value_c,
	output logic signed [31:0] value_d,
	output logic               mag_seen,
	output logic               pressure_seen
);
	import imufd_pkg::*;

	logic [POS_W-1:0] pos_q;
	logic [7:0]       fb_q [BODY_BYTES];
	logic             mag_flag_q;
	logic             pres_flag_q;

	logic             in_acc;
	logic             at_csum;
	logic [IDX_W-1:0] wr_idx;
	logic             known;
	kind_t            kind_d;
	lane_s1_t         lanes_d [LANES];
	logic [15:0]      words [LANES];
	logic             launch;

	logic             valid_s1, valid_s2, valid_s3, out_valid_q;
	logic             adv1, adv2, adv3;
	kind_t            kind_s1, kind_s2, kind_s3, kind_q;
	logic [1:0]       flags_s1, flags_s2, flags_s3, flags_q;
	lane_s1_t         lane_s1 [LANES];
	lane_s2_t         lane_s2 [LANES];
	lane_s3_t         lane_s3 [LANES];
	lane_s2_t         nx_s2 [LANES];
	lane_s3_t         nx_s3 [LANES];
	logic [31:0]      nx_res [LANES];
	logic [31:0]      res_q [LANES];

	assign in_acc  = in_valid & ~in_stall;
	assign at_csum = pos_q >= POS_W'(CSUM_POS);
	assign wr_idx  = IDX_W'(pos_q - POS_W'(1));

	// Hold a checksum byte while the first stage cannot take a new frame
	assign in_stall = at_csum & valid_s1 & ~adv1;

	// Advance the byte position: hunt, collect, wrap on the checksum byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (in_acc) begin
			if (pos_q == '0) begin
				if (rx_byte == HDR_BYTE) begin
					pos_q <= POS_W'(1);
				end
			end else if (!at_csum) begin
				pos_q <= pos_q + POS_W'(1);
			end else begin
				pos_q <= '0;
			end
		end
	end

	// Store type and data bytes
	always_ff @(posedge clk) begin
		if (in_acc && pos_q != '0 && !at_csum) begin
			fb_q[wr_idx] <= rx_byte;
		end
	end

	// Decode the collected frame into four lanes
	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			words[i]   = {fb_q[2*i+2], fb_q[2*i+1]};
			lanes_d[i] = lane_from_value(32'd0);
		end
		known  = 1'b1;
		kind_d = KIND_TIME;
		unique case (fb_q[0])
			TYPE_TIME: begin
				kind_d     = KIND_TIME;
				lanes_d[0] = lane_from_value({8'h00, fb_q[1], fb_q[2], fb_q[3]});
				lanes_d[1] = lane_from_value({8'h00, fb_q[4], fb_q[5], fb_q[6]});
				lanes_d[2] = lane_from_value({{16{words[3][15]}}, words[3]});
			end
			TYPE_ACCEL: begin
				kind_d = KIND_ACCEL;
				for (int i = 0; i < 3; i++) begin
					lanes_d[i] = lane_from_word(SC_ACCEL, words[i]);
				end
				lanes_d[3] = lane_from_word(SC_TEMP, words[3]);
			end
			TYPE_GYRO: begin
				kind_d = KIND_GYRO;
				for (int i = 0; i < 3; i++) begin
					lanes_d[i] = lane_from_word(SC_GYRO, words[i]);
				end
				lanes_d[3] = lane_from_word(SC_TEMP, words[3]);
			end
			TYPE_ANGLE: begin
				kind_d = KIND_ANGLE;
				for (int i = 0; i < 3; i++) begin
					lanes_d[i] = lane_from_value({{16{words[i][15]}}, words[i]});
				end
				lanes_d[3] = lane_from_word(SC_TEMP, words[3]);
			end
			TYPE_MAG: begin
				kind_d = KIND_MAG;
				for (int i = 0; i < 3; i++) begin
					lanes_d[i] = lane_from_word(SC_MAG, words[i]);
				end
				lanes_d[3] = lane_from_word(SC_TEMP, words[3]);
			end
			TYPE_PRESS: begin
				kind_d     = KIND_PRESS;
				lanes_d[0] = lane_from_value({fb_q[4], fb_q[3], fb_q[2], fb_q[1]});
				lanes_d[1] = lane_from_value({fb_q[8], fb_q[7], fb_q[6], fb_q[5]});
			end
			TYPE_QUAT: begin
				kind_d = KIND_QUAT;
				for (int i = 0; i < LANES; i++) begin
					lanes_d[i] = lane_from_value({{15{words[i][15]}}, words[i], 1'b0});
				end
			end
			default: begin
				known = 1'b0;
			end
		endcase
	end

	assign launch = in_acc & at_csum & known;

	// Set sticky flags when a magnetic or pressure frame launches
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mag_flag_q  <= 1'b0;
			pres_flag_q <= 1'b0;
		end else if (launch) begin
			if (kind_d == KIND_MAG) begin
				mag_flag_q <= 1'b1;
			end
			if (kind_d == KIND_PRESS) begin
				pres_flag_q <= 1'b1;
			end
		end
	end

	// Stage handshake: a stage moves on when the next one is free or moving
	assign adv3 = valid_s3 & (~out_valid_q | ~out_stall);
	assign adv2 = valid_s2 & (~valid_s3 | adv3);
	assign adv1 = valid_s1 & (~valid_s2 | adv2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			valid_s1    <= launch | (valid_s1 & ~adv1);
			valid_s2    <= adv1 | (valid_s2 & ~adv2);
			valid_s3    <= adv2 | (valid_s3 & ~adv3);
			out_valid_q <= adv3 | (out_valid_q & out_stall);
		end
	end

	// Multiply the magnitude and add the rounding offset
	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			logic [33:0] prod;
			prod = 34'(lane_s1[i].mag) * 34'(scale_mul(lane_s1[i].scale))
			     + 34'(scale_add(lane_s1[i].scale));
			nx_s2[i].scale = lane_s1[i].scale;
			nx_s2[i].neg   = lane_s1[i].neg;
			nx_s2[i].pass  = lane_s1[i].pass;
			if (lane_s1[i].scale == SC_GYRO) begin
				nx_s2[i].dvd  = DIVIDEND_W'(prod >> GYRO_PRE);
				nx_s2[i].base = 23'(lane_s1[i].mag) * 23'(GYRO_WHOLE);
			end else begin
				nx_s2[i].dvd  = DIVIDEND_W'(prod);
				nx_s2[i].base = 23'd0;
			end
		end
	end

	// Divide by the constant through its reciprocal
	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			logic [60:0] recp;
			recp = 61'(lane_s2[i].dvd) * 61'(scale_rcp(lane_s2[i].scale));
			nx_s3[i].scale = lane_s2[i].scale;
			nx_s3[i].neg   = lane_s2[i].neg;
			nx_s3[i].base  = lane_s2[i].base;
			nx_s3[i].pass  = lane_s2[i].pass;
			case (lane_s2[i].scale) inside
				SC_ACCEL:        nx_s3[i].quo = 25'(recp >> POST_DIV5);
				SC_GYRO:         nx_s3[i].quo = 25'(recp >> POST_GYRO);
				SC_MAG, SC_TEMP: nx_s3[i].quo = 25'(recp >> POST_DIV25);
				default:         nx_s3[i].quo = 25'd0;
			endcase
		end
	end

	// Add the whole part, restore the sign or take the raw value
	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			logic [25:0] sum;
			sum = 26'(lane_s3[i].quo) + 26'(lane_s3[i].base);
			if (lane_s3[i].scale == SC_PASS) begin
				nx_res[i] = lane_s3[i].pass;
			end else if (lane_s3[i].neg) begin
				nx_res[i] = 32'd0 - 32'(sum);
			end else begin
				nx_res[i] = 32'(sum);
			end
		end
	end

	// Pipeline payload registers
	always_ff @(posedge clk) begin
		if (launch) begin
			kind_s1  <= kind_d;
			flags_s1 <= {mag_flag_q | (kind_d == KIND_MAG),
			             pres_flag_q | (kind_d == KIND_PRESS)};
			for (int i = 0; i < LANES; i++) begin
				lane_s1[i] <= lanes_d[i];
			end
		end
		if (adv1) begin
			kind_s2  <= kind_s1;
			flags_s2 <= flags_s1;
			for (int i = 0; i < LANES; i++) begin
				lane_s2[i] <= nx_s2[i];
			end
		end
		if (adv2) begin
			kind_s3  <= kind_s2;
			flags_s3 <= flags_s2;
			for (int i = 0; i < LANES; i++) begin
				lane_s3[i] <= nx_s3[i];
			end
		end
		if (adv3) begin
			kind_q  <= kind_s3;
			flags_q <= flags_s3;
			for (int i = 0; i < LANES; i++) begin
				res_q[i] <= nx_res[i];
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign record_kind   = kind_q;
	assign value_a       = res_q[0];
	assign value_b       = res_q[1];
	assign value_c       = res_q[2];
	assign value_d       = res_q[3];
	assign mag_seen      = flags_q[1];
	assign pressure_seen = flags_q[0];

`ifndef SYNTHESIS
	// The byte position never passes the checksum slot
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= POS_W'(CSUM_POS))
		else $error("byte position beyond checksum slot");

	// Input is held back only on a checksum byte
	a_stall_csum: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> at_csum)
		else $error("input stalled outside checksum slot");

	// A launched frame always lands in the first stage
	a_launch_lands: assert property (@(posedge clk) disable iff (!arst_n)
		launch |-> (!valid_s1 || adv1))
		else $error("frame launched into a blocked stage");

	// Sticky flags never clear
	a_mag_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		mag_flag_q |=> mag_flag_q)
		else $error("magnetic flag cleared");

	a_pres_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		pres_flag_q |=> pres_flag_q)
		else $error("pressure flag cleared");
`endif

endmodule
